[rtl/core/date_period_overlap_days_unit_assert.svh]
// Assertion macros for the date period overlap unit.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DATE_PERIOD_OVERLAP_DAYS_UNIT_ASSERT_SVH
`define DATE_PERIOD_OVERLAP_DAYS_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define DPOD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpod check failed (same cycle)");
// next-cycle implication
`define DPOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpod check failed (next cycle)");
`else
`define DPOD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DPOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/dpod_pkg.sv]
// Types, constants and calendar helpers for the date period overlap unit.
// No dependencies; imported by the lane, merge and top-level modules.
package dpod_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SERIAL_W = 22;
    localparam int DOY_W    = 9;
    localparam int Q100_W   = 8;
    localparam int Q400_W   = 6;
    localparam int NUM_DATES = 4;

    // lane order
    localparam int LANE_S1 = 0;
    localparam int LANE_E1 = 1;
    localparam int LANE_S2 = 2;
    localparam int LANE_E2 = 3;

    typedef logic [YEAR_W-1:0]   year_t;
    typedef logic [MONTH_W-1:0]  month_t;
    typedef logic [DAY_W-1:0]    day_t;
    typedef logic [SERIAL_W-1:0] serial_t;
    typedef logic [DOY_W-1:0]    doy_t;
    typedef logic [Q100_W-1:0]   q100_t;
    typedef logic [Q400_W-1:0]   q400_t;

    localparam year_t   YEAR_MAX      = YEAR_W'(9999);
    localparam month_t  MONTH_FEB     = MONTH_W'(2);
    localparam month_t  MONTH_DEC     = MONTH_W'(12);
    localparam serial_t DAYS_PER_YEAR = SERIAL_W'(365);

    // x/25 for x < 4096 as (x * 1311) >> 15; error stays below 1/25
    localparam int RECIP25_W     = 11;
    localparam int RECIP25_SHIFT = 15;
    localparam logic [RECIP25_W-1:0] RECIP25 = RECIP25_W'(1311);

    typedef struct packed {
        logic conv_en;   // lane first stage
        logic sum_en;    // lane serial stage
    } dpod_lane_ctrl_t;

    typedef struct packed {
        logic sel_en;    // min/max stage
        logic cnt_en;    // result register
    } dpod_merge_ctrl_t;

    function automatic q100_t div25(input logic [YEAR_W-3:0] x);
        logic [YEAR_W-2+RECIP25_W-1:0] prod;
        prod = (YEAR_W-2+RECIP25_W)'(x) * (YEAR_W-2+RECIP25_W)'(RECIP25);
        return prod[RECIP25_SHIFT +: Q100_W];
    endfunction

    function automatic day_t month_len(input month_t m, input logic leap);
        day_t len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                     len = DAY_W'(30);
            4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
            default: len = '0;
        endcase
        return len;
    endfunction

    function automatic doy_t days_before(input month_t m);
        doy_t n;
        case (m)
            4'd1:    n = DOY_W'(0);
            4'd2:    n = DOY_W'(31);
            4'd3:    n = DOY_W'(59);
            4'd4:    n = DOY_W'(90);
            4'd5:    n = DOY_W'(120);
            4'd6:    n = DOY_W'(151);
            4'd7:    n = DOY_W'(181);
            4'd8:    n = DOY_W'(212);
            4'd9:    n = DOY_W'(243);
            4'd10:   n = DOY_W'(273);
            4'd11:   n = DOY_W'(304);
            4'd12:   n = DOY_W'(334);
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

[rtl/core/dpod_lane.sv]
// One date-to-serial lane: checks a date and turns it into a day number
// (day 0 is 0001-01-01) over two register stages. Depends on dpod_pkg.
module dpod_lane (
    input  logic                      clk,
    input  dpod_pkg::dpod_lane_ctrl_t ctrl,
    input  dpod_pkg::year_t           year,
    input  dpod_pkg::month_t          month,
    input  dpod_pkg::day_t            day,
    output dpod_pkg::serial_t         serial,
    output logic                      ok
);
    import dpod_pkg::*;

    year_t p;
    q100_t q_y100;
    q100_t q_p100;
    q100_t q_y400;
    q100_t q_p400;
    logic  leap;
    logic  date_ok;
    day_t  len;
    doy_t  doy;

    year_t   p_reg;
    q100_t   q100_reg;
    q400_t   q400_reg;
    doy_t    doy_reg;
    logic    ok1_reg;
    serial_t serial_reg;
    logic    ok2_reg;
    serial_t serial_next;

    // year 0 wraps p; flagged invalid below so the garbage never matters
    assign p      = year - YEAR_W'(1);
    assign q_y100 = div25(year[YEAR_W-1:2]);
    assign q_p100 = div25(p[YEAR_W-1:2]);
    assign q_y400 = div25({2'b00, year[YEAR_W-1:4]});
    assign q_p400 = div25({2'b00, p[YEAR_W-1:4]});

    // a multiple of 100 (or 400) is where the quotient steps from year-1 to year
    assign leap = (year[1:0] == 2'b00) && ((q_y100 == q_p100) || (q_y400 != q_p400));
    assign len  = month_len(month, leap);

    assign date_ok = (year != '0) && (year <= YEAR_MAX)
                   && (month != '0) && (month <= MONTH_DEC)
                   && (day != '0) && (day <= len);

    assign doy = days_before(month) + DOY_W'(day) - DOY_W'(1)
               + DOY_W'((month > MONTH_FEB) && leap);

    always_ff @(posedge clk)
    begin
        if (ctrl.conv_en)
        begin
            p_reg    <= p;
            q100_reg <= q_p100;
            q400_reg <= q_p400[Q400_W-1:0];
            doy_reg  <= doy;
            ok1_reg  <= date_ok;
        end
    end

    assign serial_next = SERIAL_W'(p_reg) * DAYS_PER_YEAR
                       + SERIAL_W'(p_reg[YEAR_W-1:2])
                       - SERIAL_W'(q100_reg)
                       + SERIAL_W'(q400_reg)
                       + SERIAL_W'(doy_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            serial_reg <= serial_next;
            ok2_reg    <= ok1_reg;
        end
    end

    assign serial = serial_reg;
    assign ok     = ok2_reg;

endmodule

[rtl/core/dpod_merge.sv]
// Merge stage: combines the four lane day numbers into the inclusive overlap
// count and the bad-date flag, over two register stages. Depends on dpod_pkg.
module dpod_merge (
    input  logic                             clk,
    input  dpod_pkg::dpod_merge_ctrl_t       ctrl,
    input  dpod_pkg::serial_t [dpod_pkg::NUM_DATES-1:0] serial,
    input  logic [dpod_pkg::NUM_DATES-1:0]   ok,
    output dpod_pkg::serial_t                count,
    output logic                             bad
);
    import dpod_pkg::*;

    serial_t lo;
    serial_t hi;
    logic    ordered;

    serial_t lo_reg;
    serial_t hi_reg;
    logic    live_reg;
    logic    bad_sel_reg;
    serial_t count_reg;
    logic    bad_reg;
    serial_t count_next;

    assign lo = (serial[LANE_S1] > serial[LANE_S2]) ? serial[LANE_S1] : serial[LANE_S2];
    assign hi = (serial[LANE_E1] < serial[LANE_E2]) ? serial[LANE_E1] : serial[LANE_E2];
    assign ordered = (serial[LANE_S1] <= serial[LANE_E1])
                   && (serial[LANE_S2] <= serial[LANE_E2]);

    always_ff @(posedge clk)
    begin
        if (ctrl.sel_en)
        begin
            lo_reg      <= lo;
            hi_reg      <= hi;
            live_reg    <= ordered && (&ok);
            bad_sel_reg <= ~(&ok);
        end
    end

    assign count_next = (live_reg && (lo_reg <= hi_reg))
                      ? (hi_reg - lo_reg + SERIAL_W'(1)) : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.cnt_en)
        begin
            count_reg <= count_next;
            bad_reg   <= bad_sel_reg;
        end
    end

    assign count = count_reg;
    assign bad   = bad_reg;

endmodule

[rtl/core/date_period_overlap_days_unit.sv]
// Channel | handshake            | payload
// req     | req_valid, req_ready | first_/second_ start/end year, month, day
// res     | res_valid, res_ready | overlap_days, bad_date
//
// Four lanes turn the four dates into day numbers; a merge stage forms the count.
// Items pass through a four-stage register pipeline (two lane stages, two merge
// stages); one item per cycle sustained while res_ready stays high.
// rst_n clears only the stage valid bits; the datapath registers hold no reset.
// A stalled res stage holds; bubbles in earlier stages still fill, and
// req_ready drops only once every stage holds an item.
// Depends on dpod_pkg, dpod_lane, dpod_merge and the assertion header.
`include "date_period_overlap_days_unit_assert.svh"

module date_period_overlap_days_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  dpod_pkg::year_t    first_start_year,
    input  dpod_pkg::month_t   first_start_month,
    input  dpod_pkg::day_t     first_start_day,
    input  dpod_pkg::year_t    first_end_year,
    input  dpod_pkg::month_t   first_end_month,
    input  dpod_pkg::day_t     first_end_day,
    input  dpod_pkg::year_t    second_start_year,
    input  dpod_pkg::month_t   second_start_month,
    input  dpod_pkg::day_t     second_start_day,
    input  dpod_pkg::year_t    second_end_year,
    input  dpod_pkg::month_t   second_end_month,
    input  dpod_pkg::day_t     second_end_day,
    output logic               res_valid,
    input  logic               res_ready,
    output dpod_pkg::serial_t  overlap_days,
    output logic               bad_date
);
    import dpod_pkg::*;

    year_t  [NUM_DATES-1:0] year_in;
    month_t [NUM_DATES-1:0] month_in;
    day_t   [NUM_DATES-1:0] day_in;
    serial_t [NUM_DATES-1:0] serial;
    logic   [NUM_DATES-1:0] ok;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic en1, en2, en3, en4;

    dpod_lane_ctrl_t  lane_ctrl;
    dpod_merge_ctrl_t merge_ctrl;

    assign year_in[LANE_S1]  = first_start_year;
    assign month_in[LANE_S1] = first_start_month;
    assign day_in[LANE_S1]   = first_start_day;
    assign year_in[LANE_E1]  = first_end_year;
    assign month_in[LANE_E1] = first_end_month;
    assign day_in[LANE_E1]   = first_end_day;
    assign year_in[LANE_S2]  = second_start_year;
    assign month_in[LANE_S2] = second_start_month;
    assign day_in[LANE_S2]   = second_start_day;
    assign year_in[LANE_E2]  = second_end_year;
    assign month_in[LANE_E2] = second_end_month;
    assign day_in[LANE_E2]   = second_end_day;

    // a stage moves when it is empty or the next one moves
    assign en4 = !v4_reg || res_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign req_ready = en1;

    assign lane_ctrl.conv_en = en1;
    assign lane_ctrl.sum_en  = en2;
    assign merge_ctrl.sel_en = en3;
    assign merge_ctrl.cnt_en = en4;

    assign v1_next = en1 ? req_valid : v1_reg;
    assign v2_next = en2 ? v1_reg    : v2_reg;
    assign v3_next = en3 ? v2_reg    : v3_reg;
    assign v4_next = en4 ? v3_reg    : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    for (genvar i = 0; i < NUM_DATES; i++)
    begin : g_lane
        dpod_lane u_lane (
            .clk    (clk),
            .ctrl   (lane_ctrl),
            .year   (year_in[i]),
            .month  (month_in[i]),
            .day    (day_in[i]),
            .serial (serial[i]),
            .ok     (ok[i])
        );
    end

    dpod_merge u_merge (
        .clk    (clk),
        .ctrl   (merge_ctrl),
        .serial (serial),
        .ok     (ok),
        .count  (overlap_days),
        .bad    (bad_date)
    );

    assign res_valid = v4_reg;

    `DPOD_ASSERT_NOW(a_bad_gives_zero, clk, rst_n, res_valid && bad_date, overlap_days == '0)
    `DPOD_ASSERT_NOW(a_count_bound, clk, rst_n, res_valid, overlap_days <= SERIAL_W'(3652059))
    `DPOD_ASSERT_NEXT(a_accept_fills, clk, rst_n, req_valid && req_ready, v1_reg)
    `DPOD_ASSERT_NEXT(a_stall_holds, clk, rst_n, v3_reg && !en4, v3_reg && v4_reg)
    `DPOD_ASSERT_NOW(a_full_blocks, clk, rst_n, v1_reg && v2_reg && v3_reg && v4_reg && !res_ready,
                     !req_ready)

endmodule

[tb/sv/date_overlap_checker.sv]
// Checker for the date period overlap unit: watches both channels, predicts
// the overlap count and bad-date flag for each item, and compares results.
// Depends on dpod_pkg for the port types.
`timescale 1ns / 1ps

module date_overlap_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  dpod_pkg::year_t    first_start_year,
    input  dpod_pkg::month_t   first_start_month,
    input  dpod_pkg::day_t     first_start_day,
    input  dpod_pkg::year_t    first_end_year,
    input  dpod_pkg::month_t   first_end_month,
    input  dpod_pkg::day_t     first_end_day,
    input  dpod_pkg::year_t    second_start_year,
    input  dpod_pkg::month_t   second_start_month,
    input  dpod_pkg::day_t     second_start_day,
    input  dpod_pkg::year_t    second_end_year,
    input  dpod_pkg::month_t   second_end_month,
    input  dpod_pkg::day_t     second_end_day,
    input  logic               res_valid,
    input  logic               res_ready,
    input  dpod_pkg::serial_t  overlap_days,
    input  logic               bad_date,
    output int                 mismatches,
    output int                 outstanding
);
    import dpod_pkg::*;

    typedef struct {
        serial_t days;
        logic    bad;
    } overlap_t;

    overlap_t expected_overlaps[$];

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input bit leap);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // day 0 is 0001-01-01; returns 0 for an invalid date
    function automatic bit day_number(input year_t y, input month_t m, input day_t d,
                                      output serial_t n);
        int unsigned p;
        int unsigned acc;
        bit leap;
        n = '0;
        if (y < 1 || y > YEAR_MAX || m < 1 || m > 12)
            return 0;
        leap = is_leap(y);
        if (d < 1 || d > month_length(m, leap))
            return 0;
        acc = 0;
        for (int i = 1; i < m; i++)
            acc += month_length(i, leap);
        p = y - 1;
        n = serial_t'(365 * p + p / 4 - p / 100 + p / 400 + acc + d - 1);
        return 1;
    endfunction

    function automatic overlap_t predict_overlap();
        overlap_t r;
        serial_t s1, e1, s2, e2, lo, hi;
        bit ok;
        ok = day_number(first_start_year, first_start_month, first_start_day, s1);
        ok = day_number(first_end_year, first_end_month, first_end_day, e1) && ok;
        ok = day_number(second_start_year, second_start_month, second_start_day, s2) && ok;
        ok = day_number(second_end_year, second_end_month, second_end_day, e2) && ok;
        r.days = '0;
        r.bad  = !ok;
        if (ok) begin
            lo = (s1 > s2) ? s1 : s2;
            hi = (e1 < e2) ? e1 : e2;
            if (s1 <= e1 && s2 <= e2 && lo <= hi)
                r.days = hi - lo + 1'b1;
        end
        return r;
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin : watch
        overlap_t exp_r;
        if (rst_n) begin
            // result first: a new item cannot produce a result in the same cycle
            if (res_valid && res_ready) begin
                if (expected_overlaps.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no item outstanding (days %0d bad %0b)",
                             $time, overlap_days, bad_date);
                end else begin
                    exp_r = expected_overlaps.pop_front();
                    if (overlap_days !== exp_r.days) begin
                        mismatches++;
                        $display("%0t: overlap_days expected %0d actual %0d",
                                 $time, exp_r.days, overlap_days);
                    end
                    if (bad_date !== exp_r.bad) begin
                        mismatches++;
                        $display("%0t: bad_date expected %0b actual %0b",
                                 $time, exp_r.bad, bad_date);
                    end
                end
            end
            if (req_valid && req_ready)
                expected_overlaps.push_back(predict_overlap());
            outstanding = expected_overlaps.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// Top of the date period overlap testbench: clock, reset, item stimulus
// with random idling on both sides, and the verdict.
// Depends on dpod_pkg, date_period_overlap_days_unit and date_overlap_checker.
`timescale 1ns / 1ps

module tb;
    import dpod_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 12;

    typedef struct {
        year_t  year;
        month_t month;
        day_t   day;
    } date_t;

    typedef struct {
        date_t s1, e1, s2, e2;
    } period_pair_t;

    logic    clk;
    logic    rst_n;
    logic    req_valid;
    logic    req_ready;
    year_t   first_start_year, first_end_year, second_start_year, second_end_year;
    month_t  first_start_month, first_end_month, second_start_month, second_end_month;
    day_t    first_start_day, first_end_day, second_start_day, second_end_day;
    logic    res_valid;
    logic    res_ready;
    serial_t overlap_days;
    logic    bad_date;
    int      mismatches;
    int      outstanding;
    int      drain_fails;
    bit      stall_on;

    date_period_overlap_days_unit dut (.*);
    date_overlap_checker          checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random back-pressure while stalling is on
    always @(negedge clk)
        res_ready <= !stall_on || ($urandom_range(0, 99) >= 26);

    function automatic period_pair_t make_pair(
        input int y1, input int m1, input int d1, input int y2, input int m2, input int d2,
        input int y3, input int m3, input int d3, input int y4, input int m4, input int d4);
        period_pair_t p;
        p.s1 = '{year_t'(y1), month_t'(m1), day_t'(d1)};
        p.e1 = '{year_t'(y2), month_t'(m2), day_t'(d2)};
        p.s2 = '{year_t'(y3), month_t'(m3), day_t'(d3)};
        p.e2 = '{year_t'(y4), month_t'(m4), day_t'(d4)};
        return p;
    endfunction

    function automatic date_t random_date(input int lo_year, input int hi_year);
        date_t d;
        d.year  = year_t'($urandom_range(lo_year, hi_year));
        d.month = month_t'($urandom_range(1, 12));
        // late days are sometimes past the month's end
        d.day   = ($urandom_range(0, 99) < 6) ? day_t'($urandom_range(29, 31))
                                              : day_t'($urandom_range(1, 28));
        return d;
    endfunction

    function automatic date_t raw_date();
        date_t d;
        d.year  = year_t'($urandom_range(0, 16383));
        d.month = month_t'($urandom_range(0, 15));
        d.day   = day_t'($urandom_range(0, 31));
        return d;
    endfunction

    function automatic bit later(input date_t a, input date_t b);
        return {a.year, a.month, a.day} > {b.year, b.month, b.day};
    endfunction

    function automatic period_pair_t random_pair();
        period_pair_t p;
        date_t tmp;
        int kind;
        int base;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            p.s1 = raw_date();
            p.e1 = raw_date();
            p.s2 = raw_date();
            p.e2 = raw_date();
        end else begin
            if (kind < 22) begin
                p.s1 = random_date(1, 9999);
                p.e1 = random_date(1, 9999);
                p.s2 = random_date(1, 9999);
                p.e2 = random_date(1, 9999);
            end else begin
                base = $urandom_range(1, 9996);
                p.s1 = random_date(base, base + 3);
                p.e1 = random_date(base, base + 3);
                p.s2 = random_date(base, base + 3);
                p.e2 = random_date(base, base + 3);
            end
            // mostly well-ordered periods; the rest stay as drawn
            if ($urandom_range(0, 99) < 85 && later(p.s1, p.e1)) begin
                tmp = p.s1; p.s1 = p.e1; p.e1 = tmp;
            end
            if ($urandom_range(0, 99) < 85 && later(p.s2, p.e2)) begin
                tmp = p.s2; p.s2 = p.e2; p.e2 = tmp;
            end
            // touching periods
            if ($urandom_range(0, 99) < 8)
                p.s2 = p.e1;
        end
        return p;
    endfunction

    // called at a falling edge; returns at a falling edge with req_valid still high
    task automatic send_pair(input period_pair_t p);
        while (stall_on && $urandom_range(0, 99) < 26) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid          <= 1'b1;
        first_start_year   <= p.s1.year;
        first_start_month  <= p.s1.month;
        first_start_day    <= p.s1.day;
        first_end_year     <= p.e1.year;
        first_end_month    <= p.e1.month;
        first_end_day      <= p.e1.day;
        second_start_year  <= p.s2.year;
        second_start_month <= p.s2.month;
        second_start_day   <= p.s2.day;
        second_end_year    <= p.e2.year;
        second_end_month   <= p.e2.month;
        second_end_day     <= p.e2.day;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        req_valid <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        if (outstanding != 0) begin
            drain_fails++;
            $display("%0t: %0d results never arrived", $time, outstanding);
        end
        @(negedge clk);
    endtask

    initial
    begin
        period_pair_t directed[$];
        rst_n              = 1'b0;
        req_valid          = 1'b0;
        res_ready          = 1'b0;
        stall_on           = 1'b1;
        drain_fails        = 0;
        first_start_year   = '0;
        first_start_month  = '0;
        first_start_day    = '0;
        first_end_year     = '0;
        first_end_month    = '0;
        first_end_day      = '0;
        second_start_year  = '0;
        second_start_month = '0;
        second_start_day   = '0;
        second_end_year    = '0;
        second_end_month   = '0;
        second_end_day     = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // full calendar span in both periods
        directed.push_back(make_pair(1, 1, 1, 9999, 12, 31, 1, 1, 1, 9999, 12, 31));
        directed.push_back(make_pair(2000, 2, 29, 2000, 2, 29, 2000, 2, 29, 2000, 2, 29));
        directed.push_back(make_pair(1900, 2, 29, 1900, 3, 1, 1900, 1, 1, 1900, 12, 31));
        directed.push_back(make_pair(2001, 0, 1, 2001, 5, 1, 2001, 1, 1, 2001, 6, 1));
        directed.push_back(make_pair(2001, 1, 1, 2001, 13, 1, 2001, 1, 1, 2001, 6, 1));
        directed.push_back(make_pair(2001, 1, 1, 2001, 5, 1, 2001, 15, 1, 2001, 6, 1));
        directed.push_back(make_pair(2001, 1, 1, 2001, 5, 1, 2001, 1, 1, 2001, 6, 0));
        directed.push_back(make_pair(2001, 4, 31, 2001, 5, 1, 2001, 1, 1, 2001, 6, 1));
        directed.push_back(make_pair(0, 1, 1, 2001, 5, 1, 2001, 1, 1, 2001, 6, 1));
        directed.push_back(make_pair(2001, 1, 1, 16383, 15, 31, 2001, 1, 1, 2001, 6, 1));
        directed.push_back(make_pair(2001, 1, 1, 2001, 5, 1, 10000, 1, 1, 10000, 6, 1));
        // reversed first period
        directed.push_back(make_pair(2010, 6, 1, 2010, 5, 31, 2010, 1, 1, 2010, 12, 31));
        // disjoint, then touching on one day
        directed.push_back(make_pair(2010, 1, 1, 2010, 1, 31, 2010, 2, 1, 2010, 2, 28));
        directed.push_back(make_pair(2010, 1, 1, 2010, 1, 31, 2010, 1, 31, 2010, 2, 28));
        // nested
        directed.push_back(make_pair(1999, 1, 1, 2005, 12, 31, 2000, 2, 1, 2000, 3, 31));
        directed.push_back(make_pair(2024, 2, 28, 2024, 3, 1, 2024, 2, 28, 2024, 3, 1));
        directed.push_back(make_pair(1900, 2, 28, 1900, 3, 1, 1900, 2, 28, 1900, 3, 1));
        directed.push_back(make_pair(9998, 7, 1, 9999, 12, 31, 9999, 1, 31, 9999, 12, 31));
        directed.push_back(make_pair(1, 1, 1, 1, 12, 31, 1, 12, 31, 2, 1, 1));
        directed.push_back(make_pair(2400, 2, 29, 2400, 12, 31, 2100, 2, 29, 2400, 3, 1));

        @(negedge clk);
        foreach (directed[i])
            send_pair(directed[i]);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            stall_on = !(n >= 200 && n < 300);
            if (n == 320)
                drain();
            send_pair(random_pair());
        end
        stall_on = 1'b1;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && drain_fails == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
